FILE: src/tpdf_pkg.sv
package tpdf_pkg;

  // store and run limits
  localparam int unsigned MAX_PIXELS = 16384;
  localparam int unsigned MAX_SIDE   = 256;
  localparam int unsigned PASS_LIMIT = 8;

  // fixed field widths
  localparam int unsigned OP_W   = 2;
  localparam int unsigned IDX_W  = 14;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned SIDE_W = 9;

  // register port
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // item operations
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_TRANSP = 2'd2
  } reg_idx_e;

  // neighborhood taps read per pixel, in priority order after the center
  typedef enum logic [2:0] {
    TAP_C  = 3'd0,
    TAP_UP = 3'd1,
    TAP_DN = 3'd2,
    TAP_LF = 3'd3,
    TAP_RT = 3'd4
  } tap_e;

  // fill engine sequencer
  typedef enum logic [8:0] {
    ENG_IDLE     = 9'b000000001,
    ENG_DILATE   = 9'b000000010,
    ENG_DRAIN    = 9'b000000100,
    ENG_PASS_END = 9'b000001000,
    ENG_FIX_TOP  = 9'b000010000,
    ENG_FIX_BOT  = 9'b000100000,
    ENG_FIX_WR   = 9'b001000000,
    ENG_COPY     = 9'b010000000,
    ENG_COPY_END = 9'b100000000
  } eng_state_e;

  // top level item sequencer
  typedef enum logic [2:0] {
    TOP_IDLE = 3'b001,
    TOP_READ = 3'b010,
    TOP_RUN  = 3'b100
  } top_state_e;

  // image geometry and transparent code
  typedef struct packed {
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [PIX_W-1:0]  transp;
    logic              size_ok;
  } cfg_t;

  // engine memory port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_bank;
  } mem_ctl_t;

  // engine completion
  typedef struct packed {
    logic done;
    logic holes;
  } eng_done_t;

endpackage

FILE: src/tpdf_ram.sv
module tpdf_ram #(
  parameter int unsigned Depth = tpdf_pkg::MAX_PIXELS,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [tpdf_pkg::PIX_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [tpdf_pkg::PIX_W-1:0] rdata_o
);

  logic [tpdf_pkg::PIX_W-1:0] mem_q [Depth];
  logic [tpdf_pkg::PIX_W-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/tpdf_cfg.sv
module tpdf_cfg #(
  parameter int unsigned MaxPixels = tpdf_pkg::MAX_PIXELS,
  localparam int unsigned CntW = $clog2(MaxPixels + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [tpdf_pkg::APB_AW-1:0] paddr_i,
  input  logic [tpdf_pkg::APB_DW-1:0] pwdata_i,
  output logic [tpdf_pkg::APB_DW-1:0] prdata_o,
  output tpdf_pkg::cfg_t              cfg_o,
  output logic [CntW-1:0]             n_pix_o
);

  logic [tpdf_pkg::SIDE_W-1:0] width_q, height_q;
  logic [tpdf_pkg::PIX_W-1:0]  transp_q;
  logic [2*tpdf_pkg::SIDE_W-1:0] prod;
  tpdf_pkg::reg_idx_e          reg_idx;

  assign reg_idx = tpdf_pkg::reg_idx_e'(paddr_i[tpdf_pkg::APB_AW-1:2]);

  // register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= tpdf_pkg::SIDE_W'(1);
      height_q <= tpdf_pkg::SIDE_W'(1);
      transp_q <= '1;
    end else if (psel_i && penable_i && pwrite_i) begin
      case (reg_idx)
        tpdf_pkg::REG_WIDTH:  width_q  <= pwdata_i[tpdf_pkg::SIDE_W-1:0];
        tpdf_pkg::REG_HEIGHT: height_q <= pwdata_i[tpdf_pkg::SIDE_W-1:0];
        tpdf_pkg::REG_TRANSP: transp_q <= pwdata_i[tpdf_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      tpdf_pkg::REG_WIDTH:  prdata_o = tpdf_pkg::APB_DW'(width_q);
      tpdf_pkg::REG_HEIGHT: prdata_o = tpdf_pkg::APB_DW'(height_q);
      tpdf_pkg::REG_TRANSP: prdata_o = tpdf_pkg::APB_DW'(transp_q);
      default:              prdata_o = '0;
    endcase
  end

  // pixel count and size check
  assign prod = (2*tpdf_pkg::SIDE_W)'(width_q) * (2*tpdf_pkg::SIDE_W)'(height_q);

  assign cfg_o.width   = width_q;
  assign cfg_o.height  = height_q;
  assign cfg_o.transp  = transp_q;
  assign cfg_o.size_ok = (width_q != '0) && (32'(width_q) <= tpdf_pkg::MAX_SIDE) &&
                         (height_q != '0) && (32'(height_q) <= tpdf_pkg::MAX_SIDE) &&
                         (32'(prod) <= MaxPixels);
  assign n_pix_o = CntW'(prod);

endmodule

FILE: src/tpdf_engine.sv
module tpdf_engine #(
  parameter int unsigned MaxPixels = tpdf_pkg::MAX_PIXELS,
  parameter int unsigned PassLimit = tpdf_pkg::PASS_LIMIT,
  localparam int unsigned AddrW = $clog2(MaxPixels),
  localparam int unsigned CntW  = $clog2(MaxPixels + 1),
  localparam int unsigned PassW = $clog2(PassLimit)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  tpdf_pkg::cfg_t             cfg_i,
  input  logic [CntW-1:0]            n_pix_i,
  input  logic [tpdf_pkg::PIX_W-1:0] rd_data_i,
  output tpdf_pkg::mem_ctl_t         mem_ctl_o,
  output logic [AddrW-1:0]           rd_addr_o,
  output logic [AddrW-1:0]           wr_addr_o,
  output logic [tpdf_pkg::PIX_W-1:0] wr_data_o,
  output logic                       bank_o,
  output tpdf_pkg::eng_done_t        done_o
);

  tpdf_pkg::eng_state_e state_q, state_d;
  logic                 bank_q, bank_d;
  logic [PassW-1:0]     pass_q, pass_d;

  // issue stage
  logic [AddrW-1:0]            p_q, p_d;
  logic [tpdf_pkg::SIDE_W-1:0] x_q, x_d, y_q, y_d;
  tpdf_pkg::tap_e              k_q, k_d;

  // data stage
  logic                        dv_q, dv_d;
  logic                        cv_q, cv_d;
  tpdf_pkg::tap_e              dk_q, dk_d;
  logic                        dnbr_q, dnbr_d;
  logic [AddrW-1:0]            dp_q, dp_d;
  logic [tpdf_pkg::PIX_W-1:0]  acc_q, acc_d;
  logic                        found_q, found_d;
  logic [CntW-1:0]             left_q, left_d;
  logic                        any_q, any_d;

  // column fix
  logic [AddrW-1:0]            base_q, base_d;
  logic [tpdf_pkg::PIX_W-1:0]  top_q, top_d;

  logic [AddrW-1:0]            h_a, iss_addr, bot_addr;
  logic                        iss_ok, last_row, last_col, last_pix, pass_last;
  logic                        solid, top_solid, take, fin_found;
  logic [tpdf_pkg::PIX_W-1:0]  fin_col;

  assign h_a       = AddrW'(cfg_i.height);
  assign last_row  = (y_q == cfg_i.height - tpdf_pkg::SIDE_W'(1));
  assign last_col  = (x_q == cfg_i.width - tpdf_pkg::SIDE_W'(1));
  assign last_pix  = (CntW'(p_q) == n_pix_i - CntW'(1));
  assign pass_last = (({1'b0, pass_q} + (PassW+1)'(1)) == (PassW+1)'(PassLimit));
  assign bot_addr  = base_q + h_a - AddrW'(1);

  // neighbor address and edge check for the current tap
  always_comb begin
    case (k_q)
      tpdf_pkg::TAP_C: begin
        iss_addr = p_q;
        iss_ok   = 1'b1;
      end
      tpdf_pkg::TAP_UP: begin
        iss_addr = p_q - AddrW'(1);
        iss_ok   = (y_q != '0);
      end
      tpdf_pkg::TAP_DN: begin
        iss_addr = p_q + AddrW'(1);
        iss_ok   = !last_row;
      end
      tpdf_pkg::TAP_LF: begin
        iss_addr = p_q - h_a;
        iss_ok   = (x_q != '0);
      end
      tpdf_pkg::TAP_RT: begin
        iss_addr = p_q + h_a;
        iss_ok   = !last_col;
      end
      default: begin
        iss_addr = p_q;
        iss_ok   = 1'b0;
      end
    endcase
  end

  // first solid neighbor wins
  assign solid     = (rd_data_i != cfg_i.transp);
  assign top_solid = (top_q != cfg_i.transp);
  assign take      = dv_q && (dk_q != tpdf_pkg::TAP_C) && !found_q && dnbr_q && solid;
  assign fin_col   = take ? rd_data_i : acc_q;
  assign fin_found = found_q | take;

  always_comb begin
    state_d   = state_q;
    bank_d    = bank_q;
    pass_d    = pass_q;
    p_d       = p_q;
    x_d       = x_q;
    y_d       = y_q;
    k_d       = k_q;
    dv_d      = 1'b0;
    cv_d      = 1'b0;
    dk_d      = dk_q;
    dnbr_d    = dnbr_q;
    dp_d      = dp_q;
    acc_d     = acc_q;
    found_d   = found_q;
    left_d    = left_q;
    any_d     = any_q;
    base_d    = base_q;
    top_d     = top_q;
    mem_ctl_o = '0;
    rd_addr_o = '0;
    wr_addr_o = '0;
    wr_data_o = '0;
    done_o    = '0;

    // data stage: fold in one tap, write the pixel with the last tap
    if (dv_q) begin
      if (dk_q == tpdf_pkg::TAP_C) begin
        acc_d   = rd_data_i;
        found_d = solid;
        if (pass_q == '0 && !solid) begin
          any_d = 1'b1;
        end
      end else if (take) begin
        acc_d   = rd_data_i;
        found_d = 1'b1;
      end
      if (dk_q == tpdf_pkg::TAP_RT) begin
        mem_ctl_o.wr_en   = 1'b1;
        mem_ctl_o.wr_bank = ~bank_q;
        wr_addr_o         = dp_q;
        wr_data_o         = fin_col;
        if (!fin_found) begin
          left_d = left_q + CntW'(1);
        end
      end
    end

    // copy stage: mirror the final image into the scratch bank
    if (cv_q) begin
      mem_ctl_o.wr_en   = 1'b1;
      mem_ctl_o.wr_bank = ~bank_q;
      wr_addr_o         = dp_q;
      wr_data_o         = rd_data_i;
    end

    // sequencer
    case (state_q)
      tpdf_pkg::ENG_IDLE: begin
        if (start_i) begin
          state_d = tpdf_pkg::ENG_DILATE;
          pass_d  = '0;
          p_d     = '0;
          x_d     = '0;
          y_d     = '0;
          k_d     = tpdf_pkg::TAP_C;
          left_d  = '0;
          any_d   = 1'b0;
        end
      end
      tpdf_pkg::ENG_DILATE: begin
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = iss_addr;
        dv_d            = 1'b1;
        dk_d            = k_q;
        dnbr_d          = iss_ok;
        dp_d            = p_q;
        case (k_q)
          tpdf_pkg::TAP_C:  k_d = tpdf_pkg::TAP_UP;
          tpdf_pkg::TAP_UP: k_d = tpdf_pkg::TAP_DN;
          tpdf_pkg::TAP_DN: k_d = tpdf_pkg::TAP_LF;
          tpdf_pkg::TAP_LF: k_d = tpdf_pkg::TAP_RT;
          tpdf_pkg::TAP_RT: begin
            k_d = tpdf_pkg::TAP_C;
            p_d = p_q + AddrW'(1);
            if (last_row) begin
              y_d = '0;
              x_d = x_q + tpdf_pkg::SIDE_W'(1);
            end else begin
              y_d = y_q + tpdf_pkg::SIDE_W'(1);
            end
            if (last_pix) begin
              state_d = tpdf_pkg::ENG_DRAIN;
            end
          end
          default: k_d = tpdf_pkg::TAP_C;
        endcase
      end
      tpdf_pkg::ENG_DRAIN: begin
        state_d = tpdf_pkg::ENG_PASS_END;
      end
      tpdf_pkg::ENG_PASS_END: begin
        // the written bank becomes the image
        bank_d = ~bank_q;
        if (left_q == '0 || left_q == n_pix_i || pass_last) begin
          state_d = tpdf_pkg::ENG_FIX_TOP;
          x_d     = '0;
          base_d  = '0;
        end else begin
          state_d = tpdf_pkg::ENG_DILATE;
          pass_d  = pass_q + PassW'(1);
          p_d     = '0;
          x_d     = '0;
          y_d     = '0;
          k_d     = tpdf_pkg::TAP_C;
          left_d  = '0;
        end
      end
      tpdf_pkg::ENG_FIX_TOP: begin
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = base_q;
        state_d         = tpdf_pkg::ENG_FIX_BOT;
      end
      tpdf_pkg::ENG_FIX_BOT: begin
        top_d           = rd_data_i;
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = bot_addr;
        state_d         = tpdf_pkg::ENG_FIX_WR;
      end
      tpdf_pkg::ENG_FIX_WR: begin
        // bottom pixel is on the read port now
        mem_ctl_o.wr_bank = bank_q;
        if (top_solid && !solid) begin
          mem_ctl_o.wr_en = 1'b1;
          wr_addr_o       = bot_addr;
          wr_data_o       = top_q;
        end else if (!top_solid && solid) begin
          mem_ctl_o.wr_en = 1'b1;
          wr_addr_o       = base_q;
          wr_data_o       = rd_data_i;
        end
        if (last_col) begin
          state_d = tpdf_pkg::ENG_COPY;
          p_d     = '0;
        end else begin
          state_d = tpdf_pkg::ENG_FIX_TOP;
          x_d     = x_q + tpdf_pkg::SIDE_W'(1);
          base_d  = base_q + h_a;
        end
      end
      tpdf_pkg::ENG_COPY: begin
        // stream the image out of the current bank, one pixel a cycle
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = p_q;
        cv_d            = 1'b1;
        dp_d            = p_q;
        p_d             = p_q + AddrW'(1);
        if (last_pix) begin
          state_d = tpdf_pkg::ENG_COPY_END;
        end
      end
      tpdf_pkg::ENG_COPY_END: begin
        state_d      = tpdf_pkg::ENG_IDLE;
        done_o.done  = 1'b1;
        done_o.holes = any_q;
      end
      default: state_d = tpdf_pkg::ENG_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpdf_pkg::ENG_IDLE;
      bank_q  <= 1'b0;
      pass_q  <= '0;
      dv_q    <= 1'b0;
      cv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      pass_q  <= pass_d;
      dv_q    <= dv_d;
      cv_q    <= cv_d;
    end
  end

  // counters and data path
  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    x_q     <= x_d;
    y_q     <= y_d;
    k_q     <= k_d;
    dk_q    <= dk_d;
    dnbr_q  <= dnbr_d;
    dp_q    <= dp_d;
    acc_q   <= acc_d;
    found_q <= found_d;
    left_q  <= left_d;
    any_q   <= any_d;
    base_q  <= base_d;
    top_q   <= top_d;
  end

  assign bank_o = bank_q;

endmodule

FILE: src/transparent_pixel_dilation_fill_top.sv
// Holds a column-major image of 8-bit palette indices in two banks of
// MaxPixels-entry single-port-write memories and fills transparent pixels on
// a run word. Every input word gives exactly one result word. A read goes
// through the registered memory read. A run with a bad size answers with
// status 1; otherwise it runs passes, at most PassLimit of them: each pass
// reads the pixel and its four neighbors through the one read port of the
// current bank, five reads per pixel, and writes the other bank; the closing
// column step reads the top and bottom pixel of each column and fills a
// transparent one from the other, and a final copy puts the finished image
// in both banks. One word is in work at a time; a finished result waits in
// the output register, and the next word is taken only while that register
// is free or draining.
module transparent_pixel_dilation_fill_top #(
  parameter int unsigned MaxPixels = tpdf_pkg::MAX_PIXELS,
  parameter int unsigned PassLimit = tpdf_pkg::PASS_LIMIT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpdf_pkg::APB_AW-1:0] paddr,
  input  logic [tpdf_pkg::APB_DW-1:0] pwdata,
  output logic [tpdf_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tpdf_pkg::OP_W-1:0]   op_i,
  input  logic [tpdf_pkg::IDX_W-1:0]  pixel_index_i,
  input  logic [tpdf_pkg::PIX_W-1:0]  pixel_value_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [tpdf_pkg::PIX_W-1:0]  read_value_o,
  output logic                        holes_found_o,
  output logic                        status_o
);

  localparam int unsigned AddrW = $clog2(MaxPixels);
  localparam int unsigned CntW  = $clog2(MaxPixels + 1);

  tpdf_pkg::cfg_t              cfg;
  logic [CntW-1:0]             n_pix;
  tpdf_pkg::mem_ctl_t          eng_ctl;
  logic [AddrW-1:0]            eng_rd_addr, eng_wr_addr;
  logic [tpdf_pkg::PIX_W-1:0]  eng_wr_data;
  logic                        bank;
  tpdf_pkg::eng_done_t         eng_done;

  logic                        we0, we1, re;
  logic [AddrW-1:0]            waddr, raddr, host_addr;
  logic [tpdf_pkg::PIX_W-1:0]  wdata, rdata0, rdata1, rd_data;

  tpdf_pkg::top_state_e        state_q, state_d;
  logic                        rd_bad_q, rd_bad_d;
  logic                        out_valid_q, out_load;
  logic [tpdf_pkg::PIX_W-1:0]  read_value_q, read_value_d;
  logic                        holes_found_q, holes_found_d;
  logic                        status_q, status_d;

  logic                        accept, idx_ok, host_we, host_re, start;

  assign pready = 1'b1;

  tpdf_cfg #(
    .MaxPixels(MaxPixels)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .prdata_o (prdata),
    .cfg_o    (cfg),
    .n_pix_o  (n_pix)
  );

  tpdf_engine #(
    .MaxPixels(MaxPixels),
    .PassLimit(PassLimit)
  ) u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .cfg_i    (cfg),
    .n_pix_i  (n_pix),
    .rd_data_i(rd_data),
    .mem_ctl_o(eng_ctl),
    .rd_addr_o(eng_rd_addr),
    .wr_addr_o(eng_wr_addr),
    .wr_data_o(eng_wr_data),
    .bank_o   (bank),
    .done_o   (eng_done)
  );

  // accept when idle and the output register is free or draining
  assign in_stall_o = (state_q != tpdf_pkg::TOP_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign idx_ok     = (32'(pixel_index_i) < MaxPixels);
  assign host_addr  = AddrW'(pixel_index_i);
  assign host_we    = accept && (op_i == tpdf_pkg::OP_LOAD) && idx_ok;
  assign host_re    = accept && (op_i == tpdf_pkg::OP_READ) && idx_ok;
  assign start      = accept && (op_i == tpdf_pkg::OP_RUN) && cfg.size_ok;

  // memory ports: loads go to both banks so the scratch bank stays a copy
  assign we0   = host_we || (eng_ctl.wr_en && !eng_ctl.wr_bank);
  assign we1   = host_we || (eng_ctl.wr_en && eng_ctl.wr_bank);
  assign waddr = host_we ? host_addr : eng_wr_addr;
  assign wdata = host_we ? pixel_value_i : eng_wr_data;
  assign re    = host_re || eng_ctl.rd_en;
  assign raddr = host_re ? host_addr : eng_rd_addr;
  assign rd_data = bank ? rdata1 : rdata0;

  tpdf_ram #(
    .Depth(MaxPixels)
  ) u_bank0 (
    .clk_i  (clk_i),
    .we_i   (we0),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata0)
  );

  tpdf_ram #(
    .Depth(MaxPixels)
  ) u_bank1 (
    .clk_i  (clk_i),
    .we_i   (we1),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata1)
  );

  // word sequencing and result selection
  always_comb begin
    state_d       = state_q;
    rd_bad_d      = rd_bad_q;
    out_load      = 1'b0;
    read_value_d  = '0;
    holes_found_d = 1'b0;
    status_d      = 1'b0;
    case (state_q)
      tpdf_pkg::TOP_IDLE: begin
        if (accept) begin
          case (tpdf_pkg::op_e'(op_i))
            tpdf_pkg::OP_LOAD: begin
              out_load = 1'b1;
              status_d = !idx_ok;
            end
            tpdf_pkg::OP_RUN: begin
              if (cfg.size_ok) begin
                state_d = tpdf_pkg::TOP_RUN;
              end else begin
                out_load = 1'b1;
                status_d = 1'b1;
              end
            end
            tpdf_pkg::OP_READ: begin
              state_d  = tpdf_pkg::TOP_READ;
              rd_bad_d = !idx_ok;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      tpdf_pkg::TOP_READ: begin
        out_load     = 1'b1;
        read_value_d = rd_bad_q ? '0 : rd_data;
        status_d     = rd_bad_q;
        state_d      = tpdf_pkg::TOP_IDLE;
      end
      tpdf_pkg::TOP_RUN: begin
        if (eng_done.done) begin
          out_load      = 1'b1;
          holes_found_d = eng_done.holes;
          state_d       = tpdf_pkg::TOP_IDLE;
        end
      end
      default: state_d = tpdf_pkg::TOP_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpdf_pkg::TOP_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register and read flag
  always_ff @(posedge clk_i) begin
    rd_bad_q <= rd_bad_d;
    if (out_load) begin
      read_value_q  <= read_value_d;
      holes_found_q <= holes_found_d;
      status_q      <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = read_value_q;
  assign holes_found_o = holes_found_q;
  assign status_o      = status_q;

endmodule

FILE: sim/tb_transparent_pixel_dilation_fill_top.sv
module tb_transparent_pixel_dilation_fill_top;

  // unused operation code, answered with all fields zero
  localparam logic [tpdf_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_WORDS = 1250;
  localparam int unsigned LIMIT_CYCLES = 1500000;
  localparam int unsigned TAIL_CYCLES  = 20;

  typedef struct packed {
    logic [tpdf_pkg::PIX_W-1:0] read_value;
    logic                       holes_found;
    logic                       status;
  } fill_result_t;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                   kind;
    logic [tpdf_pkg::OP_W-1:0]   op;
    logic [tpdf_pkg::IDX_W-1:0]  idx;
    logic [tpdf_pkg::PIX_W-1:0]  val;
    tpdf_pkg::reg_idx_e          reg_sel;
    logic [tpdf_pkg::APB_DW-1:0] reg_data;
    logic                        typed;
    fill_result_t                want;
  } stim_row_t;

  // block ports
  logic                        clk_i;
  logic                        rst_ni        = 1'b0;
  logic                        psel          = 1'b0;
  logic                        penable       = 1'b0;
  logic                        pwrite        = 1'b0;
  logic [tpdf_pkg::APB_AW-1:0] paddr         = '0;
  logic [tpdf_pkg::APB_DW-1:0] pwdata        = '0;
  logic [tpdf_pkg::APB_DW-1:0] prdata;
  logic                        pready;
  logic                        in_valid_i    = 1'b0;
  logic                        in_stall_o;
  logic [tpdf_pkg::OP_W-1:0]   op_i          = '0;
  logic [tpdf_pkg::IDX_W-1:0]  pixel_index_i = '0;
  logic [tpdf_pkg::PIX_W-1:0]  pixel_value_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i   = 1'b0;
  logic [tpdf_pkg::PIX_W-1:0]  read_value_o;
  logic                        holes_found_o;
  logic                        status_o;

  // predicted image and geometry
  logic [tpdf_pkg::PIX_W-1:0]  pix_mem     [tpdf_pkg::MAX_PIXELS];
  logic [tpdf_pkg::PIX_W-1:0]  scratch_mem [tpdf_pkg::MAX_PIXELS];
  logic [tpdf_pkg::SIDE_W-1:0] cfg_width   = 9'd1;
  logic [tpdf_pkg::SIDE_W-1:0] cfg_height  = 9'd1;
  logic [tpdf_pkg::PIX_W-1:0]  cfg_transp  = 8'd255;

  // positions that hold a defined pixel
  bit                          loaded_map  [tpdf_pkg::MAX_PIXELS];
  int unsigned                 loaded_list [$];

  fill_result_t                pending_results [$];
  stim_row_t                   dir_rows [$];
  int unsigned                 err_count  = 0;
  int unsigned                 words_sent = 0;
  bit                          calm       = 1'b0;

  transparent_pixel_dilation_fill_top u_dut (.*);

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("== FAIL ==");
    $finish;
  end

  // expected word for one accepted input word, updating the image
  function automatic fill_result_t predict_word(input logic [tpdf_pkg::OP_W-1:0] op,
                                                input logic [tpdf_pkg::IDX_W-1:0] idx,
                                                input logic [tpdf_pkg::PIX_W-1:0] val);
    fill_result_t res;
    int unsigned w, h, n, x, y, p, pass_no, left_over;
    logic [tpdf_pkg::PIX_W-1:0] c, tv, t, b;
    bit any;
    res = '0;
    w = 32'(cfg_width);
    h = 32'(cfg_height);
    tv = cfg_transp;
    case (op)
      tpdf_pkg::OP_LOAD: begin
        if (idx < tpdf_pkg::MAX_PIXELS) pix_mem[idx] = val;
        else res.status = 1'b1;
      end
      tpdf_pkg::OP_READ: begin
        if (idx < tpdf_pkg::MAX_PIXELS) res.read_value = pix_mem[idx];
        else res.status = 1'b1;
      end
      tpdf_pkg::OP_RUN: begin
        if (w < 1 || w > tpdf_pkg::MAX_SIDE || h < 1 || h > tpdf_pkg::MAX_SIDE ||
            w * h > tpdf_pkg::MAX_PIXELS) begin
          res.status = 1'b1;
        end else begin
          n = w * h;
          any = 1'b0;
          for (p = 0; p < n; p++) if (pix_mem[p] == tv) any = 1'b1;
          // dilation passes, each reading the previous image
          for (pass_no = 0; pass_no < tpdf_pkg::PASS_LIMIT; pass_no++) begin
            left_over = 0;
            for (x = 0; x < w; x++) begin
              for (y = 0; y < h; y++) begin
                p = x * h + y;
                c = pix_mem[p];
                if (c == tv) begin
                  if (y > 0 && pix_mem[p-1] != tv) c = pix_mem[p-1];
                  else if (y + 1 < h && pix_mem[p+1] != tv) c = pix_mem[p+1];
                  else if (x > 0 && pix_mem[p-h] != tv) c = pix_mem[p-h];
                  else if (x + 1 < w && pix_mem[p+h] != tv) c = pix_mem[p+h];
                  else left_over++;
                end
                scratch_mem[p] = c;
              end
            end
            for (p = 0; p < n; p++) pix_mem[p] = scratch_mem[p];
            if (left_over == 0 || left_over == n) break;
          end
          // top and bottom of each column fill each other
          for (x = 0; x < w; x++) begin
            t = pix_mem[x*h];
            b = pix_mem[x*h+h-1];
            if (t != tv && b == tv) pix_mem[x*h+h-1] = t;
            else if (t == tv && b != tv) pix_mem[x*h] = b;
          end
          res.holes_found = any;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic stim_row_t word_row(input logic [tpdf_pkg::OP_W-1:0] op,
                                         input logic [tpdf_pkg::IDX_W-1:0] idx,
                                         input logic [tpdf_pkg::PIX_W-1:0] val,
                                         input logic typed, input fill_result_t want);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.op = op;
    r.idx = idx;
    r.val = val;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input tpdf_pkg::reg_idx_e sel,
                                        input logic [tpdf_pkg::APB_DW-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.reg_sel = sel;
    r.reg_data = data;
    return r;
  endfunction

  function automatic logic [tpdf_pkg::IDX_W-1:0] pick_loaded();
    return tpdf_pkg::IDX_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    err_count++;
  endtask

  // drive one input word and record its expected result
  task automatic send_word(input logic [tpdf_pkg::OP_W-1:0] op,
                           input logic [tpdf_pkg::IDX_W-1:0] idx,
                           input logic [tpdf_pkg::PIX_W-1:0] val, input logic typed,
                           input fill_result_t want);
    fill_result_t predicted;
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    pixel_index_i <= idx;
    pixel_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_word(op, idx, val);
    pending_results.push_back(typed ? want : predicted);
    if (op == tpdf_pkg::OP_LOAD && !loaded_map[idx]) begin
      loaded_map[idx] = 1'b1;
      loaded_list.push_back(32'(idx));
    end
    if (op != OP_UNUSED) words_sent++;
  endtask

  // hold off input until every result is back
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input tpdf_pkg::reg_idx_e sel,
                           input logic [tpdf_pkg::APB_DW-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (sel)
      tpdf_pkg::REG_WIDTH:  cfg_width  = data[tpdf_pkg::SIDE_W-1:0];
      tpdf_pkg::REG_HEIGHT: cfg_height = data[tpdf_pkg::SIDE_W-1:0];
      tpdf_pkg::REG_TRANSP: cfg_transp = data[tpdf_pkg::PIX_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // stray word: unused op, load anywhere, or read of a defined pixel
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_word(OP_UNUSED, tpdf_pkg::IDX_W'($urandom_range(tpdf_pkg::MAX_PIXELS - 1)),
                   tpdf_pkg::PIX_W'($urandom_range(255)), 1'b1, '0);
      1: send_word(tpdf_pkg::OP_LOAD,
                   tpdf_pkg::IDX_W'($urandom_range(tpdf_pkg::MAX_PIXELS - 1)),
                   tpdf_pkg::PIX_W'($urandom_range(255)), 1'b0, '0);
      default: send_word(tpdf_pkg::OP_READ, pick_loaded(), 8'd0, 1'b0, '0);
    endcase
  endtask

  // run word with random don't-care fields
  task automatic send_run();
    send_word(tpdf_pkg::OP_RUN, tpdf_pkg::IDX_W'($urandom_range(tpdf_pkg::MAX_PIXELS - 1)),
              tpdf_pkg::PIX_W'($urandom_range(255)), 1'b0, '0);
  endtask

  // result stall
  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 19);
  end

  // result check
  always @(posedge clk_i) begin
    fill_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (read_value_o !== want.read_value)
          report_mismatch($sformatf("read_value got %0d want %0d",
                                    read_value_o, want.read_value));
        if (holes_found_o !== want.holes_found)
          report_mismatch($sformatf("holes_found got %0b want %0b",
                                    holes_found_o, want.holes_found));
        if (status_o !== want.status)
          report_mismatch($sformatf("status got %0b want %0b", status_o, want.status));
      end
    end
  end

  // stimulus
  initial begin
    int unsigned phase_no, start_words, w, h, n, p, k, dens, reads;
    logic [tpdf_pkg::PIX_W-1:0] tv, v;
    bit backward;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows, reset geometry is a single transparent-255 pixel
    dir_rows.push_back(word_row(tpdf_pkg::OP_LOAD, 14'd0, 8'd255, 1'b1, '{8'd0, 1'b0, 1'b0}));
    dir_rows.push_back(word_row(tpdf_pkg::OP_RUN, 14'd0, 8'd0, 1'b1, '{8'd0, 1'b1, 1'b0}));
    dir_rows.push_back(word_row(tpdf_pkg::OP_READ, 14'd0, 8'd0, 1'b1, '{8'd255, 1'b0, 1'b0}));
    dir_rows.push_back(word_row(tpdf_pkg::OP_LOAD, 14'd16383, 8'd0, 1'b1,
                                '{8'd0, 1'b0, 1'b0}));
    dir_rows.push_back(word_row(tpdf_pkg::OP_READ, 14'd16383, 8'd255, 1'b1,
                                '{8'd0, 1'b0, 1'b0}));
    dir_rows.push_back(word_row(OP_UNUSED, 14'd16383, 8'd255, 1'b1, '{8'd0, 1'b0, 1'b0}));
    dir_rows.push_back(word_row(tpdf_pkg::OP_LOAD, 14'd0, 8'd0, 1'b1, '{8'd0, 1'b0, 1'b0}));
    dir_rows.push_back(word_row(tpdf_pkg::OP_RUN, 14'd0, 8'd0, 1'b1, '{8'd0, 1'b0, 1'b0}));
    // bad sizes: zero, beyond the side limit, too many pixels
    dir_rows.push_back(reg_row(tpdf_pkg::REG_WIDTH, 32'd0));
    dir_rows.push_back(word_row(tpdf_pkg::OP_RUN, 14'd0, 8'd0, 1'b1, '{8'd0, 1'b0, 1'b1}));
    dir_rows.push_back(reg_row(tpdf_pkg::REG_WIDTH, 32'd511));
    dir_rows.push_back(word_row(tpdf_pkg::OP_RUN, 14'd0, 8'd0, 1'b1, '{8'd0, 1'b0, 1'b1}));
    dir_rows.push_back(reg_row(tpdf_pkg::REG_WIDTH, 32'd256));
    dir_rows.push_back(reg_row(tpdf_pkg::REG_HEIGHT, 32'd65));
    dir_rows.push_back(word_row(tpdf_pkg::OP_RUN, 14'd0, 8'd0, 1'b1, '{8'd0, 1'b0, 1'b1}));
    dir_rows.push_back(reg_row(tpdf_pkg::REG_WIDTH, 32'd1));
    dir_rows.push_back(reg_row(tpdf_pkg::REG_HEIGHT, 32'd0));
    dir_rows.push_back(word_row(tpdf_pkg::OP_RUN, 14'd0, 8'd0, 1'b1, '{8'd0, 1'b0, 1'b1}));
    // small 2x3 image with transparent code 0
    dir_rows.push_back(reg_row(tpdf_pkg::REG_WIDTH, 32'd2));
    dir_rows.push_back(reg_row(tpdf_pkg::REG_HEIGHT, 32'd3));
    dir_rows.push_back(reg_row(tpdf_pkg::REG_TRANSP, 32'd0));
    dir_rows.push_back(word_row(tpdf_pkg::OP_LOAD, 14'd0, 8'd0, 1'b0, '0));
    dir_rows.push_back(word_row(tpdf_pkg::OP_LOAD, 14'd1, 8'd0, 1'b0, '0));
    dir_rows.push_back(word_row(tpdf_pkg::OP_LOAD, 14'd2, 8'd200, 1'b0, '0));
    dir_rows.push_back(word_row(tpdf_pkg::OP_LOAD, 14'd3, 8'd0, 1'b0, '0));
    dir_rows.push_back(word_row(tpdf_pkg::OP_LOAD, 14'd4, 8'd77, 1'b0, '0));
    dir_rows.push_back(word_row(tpdf_pkg::OP_LOAD, 14'd5, 8'd0, 1'b0, '0));
    dir_rows.push_back(word_row(tpdf_pkg::OP_RUN, 14'd0, 8'd0, 1'b0, '0));
    for (k = 0; k < 6; k++)
      dir_rows.push_back(word_row(tpdf_pkg::OP_READ, tpdf_pkg::IDX_W'(k), 8'd0, 1'b0, '0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        settle_block();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_data);
      end else begin
        send_word(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val,
                  dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // random phases: new geometry, load image, run, read back
    start_words = words_sent;
    phase_no = 0;
    while (phase_no < 2 || words_sent - start_words < RANDOM_WORDS) begin
      calm = (phase_no >= 6 && phase_no < 10);
      if (phase_no == 0) begin
        w = 256;
        h = 1;
      end else if (phase_no == 1) begin
        w = 1;
        h = 256;
      end else begin
        case ($urandom_range(19))
          0: begin
            case ($urandom_range(2))
              0: begin
                w = $urandom_range(1) ? 0 : $urandom_range(1, 8);
                h = (w == 0) ? $urandom_range(1, 8) : 0;
              end
              1: begin
                w = $urandom_range(257, 511);
                h = $urandom_range(1, 511);
              end
              default: begin
                w = $urandom_range(65, 256);
                h = $urandom_range(tpdf_pkg::MAX_PIXELS / w + 1, 256);
              end
            endcase
          end
          1: begin
            w = $urandom_range(8, 16);
            h = $urandom_range(8, 16);
          end
          default: begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
          end
        endcase
      end
      case ($urandom_range(9))
        0: tv = 8'd0;
        1: tv = 8'd255;
        default: tv = tpdf_pkg::PIX_W'($urandom_range(255));
      endcase
      settle_block();
      write_reg(tpdf_pkg::REG_WIDTH, w);
      write_reg(tpdf_pkg::REG_HEIGHT, h);
      write_reg(tpdf_pkg::REG_TRANSP, 32'(tv));

      if (w < 1 || w > tpdf_pkg::MAX_SIDE || h < 1 || h > tpdf_pkg::MAX_SIDE ||
          w * h > tpdf_pkg::MAX_PIXELS) begin
        // broken geometry: runs are refused
        send_run();
        send_noise();
        send_run();
      end else begin
        n = w * h;
        case ($urandom_range(9))
          0: dens = 0;
          1: dens = 100;
          default: dens = $urandom_range(30, 97);
        endcase
        backward = ($urandom_range(3) == 0);
        for (k = 0; k < n; k++) begin
          p = backward ? n - 1 - k : k;
          if (!(loaded_map[p] && $urandom_range(3) == 0)) begin
            v = ($urandom_range(99) < dens) ? tv : 8'($urandom_range(255));
            send_word(tpdf_pkg::OP_LOAD, tpdf_pkg::IDX_W'(p), v, 1'b0, '0);
          end
          if ($urandom_range(15) == 0) send_noise();
        end
        if ($urandom_range(3) == 0) settle_block();
        send_run();
        if ($urandom_range(4) == 0) send_run();
        reads = (n <= 16) ? n : $urandom_range(4, 12);
        for (k = 0; k < reads; k++) begin
          p = (n <= 16) ? k : $urandom_range(n - 1);
          send_word(tpdf_pkg::OP_READ, tpdf_pkg::IDX_W'(p),
                    tpdf_pkg::PIX_W'($urandom_range(255)), 1'b0, '0);
        end
        send_word(tpdf_pkg::OP_READ, pick_loaded(), tpdf_pkg::PIX_W'($urandom_range(255)),
                  1'b0, '0);
      end
      phase_no++;
    end
    calm = 1'b0;

    // drain and finish
    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
